// ===== design/rbt_pkg.sv =====
// Shared types, codes and lookup functions for the resource barrier tracker.
`default_nettype none

package rbt_pkg;

  localparam int MAX_RESOURCES = 256;

  // Item operation codes
  localparam logic OP_DECLARE = 1'b0;
  localparam logic OP_BIND    = 1'b1;

  // Queue kinds
  localparam logic [1:0] Q_NONE     = 2'd0;
  localparam logic [1:0] Q_GRAPHICS = 2'd1;
  localparam logic [1:0] Q_TRANSFER = 2'd2;
  localparam logic [1:0] Q_COMPUTE  = 2'd3;

  // Image usages
  localparam logic [2:0] UI_COLOR    = 3'd0;
  localparam logic [2:0] UI_DEPTH    = 3'd1;
  localparam logic [2:0] UI_SHADER   = 3'd2;
  localparam logic [2:0] UI_TRANSFER = 3'd3;
  localparam logic [2:0] UI_PRESENT  = 3'd4;

  // Buffer usages
  localparam logic [2:0] UB_STORAGE  = 3'd0;
  localparam logic [2:0] UB_UNIFORM  = 3'd1;
  localparam logic [2:0] UB_VERTEX   = 3'd2;
  localparam logic [2:0] UB_INDEX    = 3'd3;
  localparam logic [2:0] UB_TRANSFER = 3'd4;
  localparam logic [2:0] UB_HOST     = 3'd5;

  // Barrier kinds
  localparam logic [1:0] BK_HAZARD  = 2'd0;
  localparam logic [1:0] BK_RELEASE = 2'd1;
  localparam logic [1:0] BK_ACQUIRE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRAPHICS = 2'd0;
  localparam logic [1:0] CFG_TRANSFER = 2'd1;
  localparam logic [1:0] CFG_COMPUTE  = 2'd2;

  // Dense layout codes
  localparam logic [2:0] LAY_UNDEF     = 3'd0;
  localparam logic [2:0] LAY_COLOR     = 3'd1;
  localparam logic [2:0] LAY_DS_ATT    = 3'd2;
  localparam logic [2:0] LAY_DS_RD     = 3'd3;
  localparam logic [2:0] LAY_SHADER_RD = 3'd4;
  localparam logic [2:0] LAY_XFER_SRC  = 3'd5;
  localparam logic [2:0] LAY_XFER_DST  = 3'd6;
  localparam logic [2:0] LAY_PRESENT   = 3'd7;

  localparam int ACC_W = 17;
  localparam int STG_W = 35;

  // Access bits
  localparam logic [ACC_W-1:0] A_INDEX_RD   = 17'h00002;
  localparam logic [ACC_W-1:0] A_VERTEX_RD  = 17'h00004;
  localparam logic [ACC_W-1:0] A_UNIFORM_RD = 17'h00008;
  localparam logic [ACC_W-1:0] A_SHADER_RD  = 17'h00020;
  localparam logic [ACC_W-1:0] A_SHADER_WR  = 17'h00040;
  localparam logic [ACC_W-1:0] A_COLOR_RD   = 17'h00080;
  localparam logic [ACC_W-1:0] A_COLOR_WR   = 17'h00100;
  localparam logic [ACC_W-1:0] A_DS_RD      = 17'h00200;
  localparam logic [ACC_W-1:0] A_DS_WR      = 17'h00400;
  localparam logic [ACC_W-1:0] A_XFER_RD    = 17'h00800;
  localparam logic [ACC_W-1:0] A_XFER_WR    = 17'h01000;
  localparam logic [ACC_W-1:0] A_HOST_RD    = 17'h02000;
  localparam logic [ACC_W-1:0] A_HOST_WR    = 17'h04000;
  localparam logic [ACC_W-1:0] A_MEM_WR     = 17'h10000;
  localparam logic [ACC_W-1:0] WRITE_BITS   =
    A_SHADER_WR | A_COLOR_WR | A_DS_WR | A_XFER_WR | A_MEM_WR;

  // Stage bits; clear, index input and vertex attribute input sit above bit 34 and drop out
  localparam logic [STG_W-1:0] S_NONE      = 35'h0;
  localparam logic [STG_W-1:0] S_FRAG      = 35'h0_0000_0080;
  localparam logic [STG_W-1:0] S_EARLY_FT  = 35'h0_0000_0100;
  localparam logic [STG_W-1:0] S_LATE_FT   = 35'h0_0000_0200;
  localparam logic [STG_W-1:0] S_COLOR_OUT = 35'h0_0000_0400;
  localparam logic [STG_W-1:0] S_COMPUTE   = 35'h0_0000_0800;
  localparam logic [STG_W-1:0] S_HOST      = 35'h0_0000_4000;
  localparam logic [STG_W-1:0] S_ALL_CMDS  = 35'h0_0001_0000;
  localparam logic [STG_W-1:0] S_COPY      = 35'h1_0000_0000;

  typedef struct packed {
    logic       operation;
    logic [7:0] resource_index;
    logic       is_texture;
    logic [3:0] owner_family;
    logic [2:0] image_aspects;
    logic [1:0] queue_kind;
    logic [2:0] usage;
    logic       is_write;
    logic       first_pass;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [2:0]       aspect;
    logic [3:0]       owner;
    logic [3:0]       family;
    logic [ACC_W-1:0] access;
    logic [STG_W-1:0] stage;
    logic [2:0]       layout;
  } entry_t;

  typedef struct packed {
    logic [3:0]       fam;
    logic [ACC_W-1:0] acc;
    logic [STG_W-1:0] stg;
    logic [2:0]       lay;
  } vstate_t;

  typedef struct packed {
    logic [3:0] graphics;
    logic [3:0] transfer;
    logic [3:0] compute;
  } fam_cfg_t;

  typedef struct packed {
    logic [7:0]       barrier_resource;
    logic [1:0]       barrier_kind;
    logic [ACC_W-1:0] src_access;
    logic [STG_W-1:0] src_stages;
    logic [2:0]       src_layout;
    logic [3:0]       src_family;
    logic [ACC_W-1:0] dst_access;
    logic [STG_W-1:0] dst_stages;
    logic [2:0]       dst_layout;
    logic [3:0]       dst_family;
    logic [2:0]       aspect_mask;
    logic             last;
  } result_t;

  // Decision of one item: table write-back and up to two barriers
  typedef struct packed {
    logic [1:0] n;
    logic       wr_en;
    entry_t     wr_entry;
    result_t    r0;
    result_t    r1;
  } resolve_t;

  function automatic vstate_t required_state(input logic tex, input logic [3:0] owner,
                                             input logic [1:0] q, input logic [2:0] use_code,
                                             input logic wr, input fam_cfg_t fams);
    vstate_t r;
    r = '0;
    if (q == Q_NONE) begin
      r.fam = owner;
      r.stg = S_ALL_CMDS;
    end else begin
      case (q)
        Q_GRAPHICS: r.fam = fams.graphics;
        Q_TRANSFER: r.fam = fams.transfer;
        default:    r.fam = fams.compute;
      endcase
      if (tex) begin
        case (use_code)
          UI_COLOR: begin
            r.acc = wr ? A_COLOR_WR : A_COLOR_RD;
            r.stg = S_COLOR_OUT;
            r.lay = LAY_COLOR;
          end
          UI_DEPTH: begin
            r.acc = wr ? A_DS_WR : A_DS_RD;
            r.stg = S_EARLY_FT | S_LATE_FT;
            r.lay = wr ? LAY_DS_ATT : LAY_DS_RD;
          end
          UI_SHADER: begin
            // shader writes keep the ds read layout
            r.acc = wr ? A_SHADER_WR : A_SHADER_RD;
            r.stg = S_FRAG | S_COMPUTE;
            r.lay = wr ? LAY_DS_RD : LAY_SHADER_RD;
          end
          UI_TRANSFER: begin
            r.acc = wr ? A_XFER_WR : A_XFER_RD;
            r.stg = S_COPY;
            r.lay = wr ? LAY_XFER_DST : LAY_XFER_SRC;
          end
          UI_PRESENT: r.lay = LAY_PRESENT;
          default: ;
        endcase
      end else begin
        case (use_code)
          UB_STORAGE: begin
            r.acc = wr ? A_SHADER_WR : A_SHADER_RD;
            r.stg = S_FRAG | S_COMPUTE;
          end
          UB_UNIFORM: begin
            r.acc = A_UNIFORM_RD;
            r.stg = S_FRAG | S_COMPUTE;
          end
          UB_VERTEX:   r.acc = A_VERTEX_RD;
          UB_INDEX:    r.acc = A_INDEX_RD;
          UB_TRANSFER: begin
            r.acc = wr ? A_XFER_WR : A_XFER_RD;
            r.stg = S_COPY;
          end
          UB_HOST: begin
            r.acc = wr ? A_HOST_WR : A_HOST_RD;
            r.stg = S_HOST;
          end
          default: ;
        endcase
      end
    end
    if (!tex) begin
      r.lay = LAY_UNDEF;
    end
    return r;
  endfunction

  function automatic logic [2:0] usage_aspects(input logic [2:0] use_code);
    logic [2:0] a;
    case (use_code)
      UI_COLOR, UI_TRANSFER, UI_PRESENT: a = 3'd1;
      UI_DEPTH:                          a = 3'd6;
      UI_SHADER:                         a = 3'd3;
      default:                           a = 3'd0;
    endcase
    return a;
  endfunction

  function automatic result_t make_result(input logic [7:0] idx, input logic [1:0] kind,
                                          input vstate_t s, input vstate_t d,
                                          input logic [2:0] asp, input logic last);
    result_t r;
    r.barrier_resource = idx;
    r.barrier_kind     = kind;
    r.src_access       = s.acc;
    r.src_stages       = s.stg;
    r.src_layout       = s.lay;
    r.src_family       = s.fam;
    r.dst_access       = d.acc;
    r.dst_stages       = d.stg;
    r.dst_layout       = d.lay;
    r.dst_family       = d.fam;
    r.aspect_mask      = asp;
    r.last             = last;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/rbt_if.sv =====
// Channel interfaces of the resource barrier tracker: items, results, configuration.
`default_nettype none

interface rbt_item_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] resource_index;
  logic       is_texture;
  logic [3:0] owner_family;
  logic [2:0] image_aspects;
  logic [1:0] queue_kind;
  logic [2:0] usage;
  logic       is_write;
  logic       first_pass;

  modport source (
    output valid, operation, resource_index, is_texture, owner_family, image_aspects,
           queue_kind, usage, is_write, first_pass,
    input  ready
  );
  modport sink (
    input  valid, operation, resource_index, is_texture, owner_family, image_aspects,
           queue_kind, usage, is_write, first_pass,
    output ready
  );
endinterface

interface rbt_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  barrier_resource;
  logic [1:0]  barrier_kind;
  logic [16:0] src_access;
  logic [34:0] src_stages;
  logic [2:0]  src_layout;
  logic [3:0]  src_family;
  logic [16:0] dst_access;
  logic [34:0] dst_stages;
  logic [2:0]  dst_layout;
  logic [3:0]  dst_family;
  logic [2:0]  aspect_mask;
  logic        last;

  modport source (
    output valid, barrier_resource, barrier_kind, src_access, src_stages, src_layout,
           src_family, dst_access, dst_stages, dst_layout, dst_family, aspect_mask, last,
    input  ready
  );
  modport sink (
    input  valid, barrier_resource, barrier_kind, src_access, src_stages, src_layout,
           src_family, dst_access, dst_stages, dst_layout, dst_family, aspect_mask, last,
    output ready
  );
endinterface

interface rbt_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/resource_barrier_tracker_core.sv =====
// Top level of the resource barrier tracker: state table memory, sequencing, result buffer.
//
// Use: item_i carries declare and bind items, result_o delivers barrier beats, cfg_i
// writes the three queue family registers (index 0 graphics, 1 transfer, 2 compute).
// A declare sets up one table entry and gives no beat. A bind reads the entry, then
// merges into it silently, or gives one hazard beat, or gives an ownership pair
// (release then acquisition, release left out on the first pass). The final beat of
// an item has last set.
// Timing: an item is accepted, the table entry is read from the synchronous memory on
// that edge, and the item is then resolved and written back from the registered entry.
// Its beats enter the result buffer on resolution and are shown on result_o from there.
// Items are taken one at a time, set by the read-then-write turn of the single table memory;
// ready stays low from each accept until that item resolves, so two binds of one entry
// never overlap.
// A two-beat result buffer sits between the table and result_o: a new item is taken
// while beats wait, and resolution waits only when the buffer lacks room.
// Reset clears the family registers and the control state; the table is not cleared,
// an entry holds garbage until its declare. cfg_i is always ready.
`default_nettype none

module resource_barrier_tracker_core #(
  parameter int MaxResources = rbt_pkg::MAX_RESOURCES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rbt_item_if.sink     item_i,
  rbt_result_if.source result_o,
  rbt_cfg_if.sink      cfg_i
);

  localparam int AddrW = (MaxResources > 1) ? $clog2(MaxResources) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic st_q, st_d;
  logic [1:0] cnt_q, cnt_d;
  logic wp_q, wp_d;
  logic rp_q, rp_d;

  rbt_pkg::fam_cfg_t fam_q;
  rbt_pkg::item_t    item_d, item_q;
  rbt_pkg::entry_t   rd_entry_q;
  rbt_pkg::entry_t   entry_mem [MaxResources];
  rbt_pkg::result_t  fifo_q [2];
  rbt_pkg::result_t  head;
  rbt_pkg::resolve_t res;

  logic             in_fire;
  logic             pop;
  logic             exec_go;
  logic [1:0]       push_n;
  logic [AddrW-1:0] in_addr;
  logic [AddrW-1:0] wr_addr;

  // Configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fam_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rbt_pkg::CFG_GRAPHICS: fam_q.graphics <= cfg_i.data;
        rbt_pkg::CFG_TRANSFER: fam_q.transfer <= cfg_i.data;
        rbt_pkg::CFG_COMPUTE:  fam_q.compute  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Item intake
  assign item_i.ready = (st_q == ST_IDLE);
  assign in_fire      = item_i.valid & item_i.ready;

  always_comb begin
    item_d.operation      = item_i.operation;
    item_d.resource_index = item_i.resource_index;
    item_d.is_texture     = item_i.is_texture;
    item_d.owner_family   = item_i.owner_family;
    item_d.image_aspects  = item_i.image_aspects;
    item_d.queue_kind     = item_i.queue_kind;
    item_d.usage          = item_i.usage;
    item_d.is_write       = item_i.is_write;
    item_d.first_pass     = item_i.first_pass;
  end

  assign in_addr = AddrW'(item_i.resource_index);
  assign wr_addr = AddrW'(item_q.resource_index);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= item_d;
    end
  end

  // State table: read on accept, written back on resolve
  always_ff @(posedge clk_i) begin
    if (exec_go && res.wr_en) begin
      entry_mem[wr_addr] <= res.wr_entry;
    end
    if (in_fire) begin
      rd_entry_q <= entry_mem[in_addr];
    end
  end

  rbt_resolve #(
    .MaxResources(MaxResources)
  ) u_resolve (
    .item_i (item_q),
    .entry_i(rd_entry_q),
    .fam_i  (fam_q),
    .res_o  (res)
  );

  assign exec_go = (st_q == ST_EXEC) && (({1'b0, cnt_q} + {1'b0, res.n}) <= 3'd2);
  assign push_n  = exec_go ? res.n : 2'd0;

  // Result buffer
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wp_q] <= res.r0;
    end
    if (push_n == 2'd2) begin
      fifo_q[~wp_q] <= res.r1;
    end
  end

  assign head = fifo_q[rp_q];
  assign pop  = result_o.valid & result_o.ready;

  assign result_o.valid            = (cnt_q != 2'd0);
  assign result_o.barrier_resource = head.barrier_resource;
  assign result_o.barrier_kind     = head.barrier_kind;
  assign result_o.src_access       = head.src_access;
  assign result_o.src_stages       = head.src_stages;
  assign result_o.src_layout       = head.src_layout;
  assign result_o.src_family       = head.src_family;
  assign result_o.dst_access       = head.dst_access;
  assign result_o.dst_stages       = head.dst_stages;
  assign result_o.dst_layout       = head.dst_layout;
  assign result_o.dst_family       = head.dst_family;
  assign result_o.aspect_mask      = head.aspect_mask;
  assign result_o.last             = head.last;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_fire) begin
        st_d = ST_EXEC;
      end
      ST_EXEC: if (exec_go) begin
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
    cnt_d = cnt_q + push_n - {1'b0, pop};
    wp_d  = (push_n == 2'd1) ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      wp_q  <= wp_d;
      rp_q  <= rp_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/rbt_resolve.sv =====
// Decision logic: required state, barrier selection and table write-back for one item.
`default_nettype none

module rbt_resolve #(
  parameter int MaxResources = rbt_pkg::MAX_RESOURCES
) (
  input  rbt_pkg::item_t    item_i,
  input  rbt_pkg::entry_t   entry_i,
  input  rbt_pkg::fam_cfg_t fam_i,
  output rbt_pkg::resolve_t res_o
);

  logic              tex;
  logic              in_range;
  logic [2:0]        asp;
  rbt_pkg::vstate_t  prev;
  rbt_pkg::vstate_t  req;
  rbt_pkg::vstate_t  zs;
  rbt_pkg::vstate_t  zd;
  rbt_pkg::entry_t   repl;
  rbt_pkg::entry_t   decl;
  rbt_pkg::entry_t   merged;

  always_comb begin
    in_range = 32'(item_i.resource_index) < MaxResources;
    tex      = entry_i.kind;

    prev.fam = entry_i.family;
    prev.acc = entry_i.access;
    prev.stg = entry_i.stage;
    prev.lay = tex ? entry_i.layout : rbt_pkg::LAY_UNDEF;

    req = rbt_pkg::required_state(tex, entry_i.owner, item_i.queue_kind, item_i.usage,
                                  item_i.is_write, fam_i);
    asp = tex ? (rbt_pkg::usage_aspects(item_i.usage) & entry_i.aspect) : 3'd0;

    // ownership transfer halves carry no access or stage bits on the far side
    zs     = prev;
    zs.acc = '0;
    zs.stg = '0;
    zd     = req;
    zd.acc = '0;
    zd.stg = '0;

    repl        = entry_i;
    repl.family = req.fam;
    repl.access = req.acc;
    repl.stage  = req.stg;
    repl.layout = req.lay;

    merged        = entry_i;
    merged.access = prev.acc | req.acc;
    merged.stage  = prev.stg | req.stg;

    decl.kind   = item_i.is_texture;
    decl.aspect = item_i.image_aspects;
    decl.owner  = item_i.owner_family;
    decl.family = item_i.owner_family;
    decl.access = '0;
    decl.stage  = rbt_pkg::S_ALL_CMDS;
    decl.layout = rbt_pkg::LAY_UNDEF;

    res_o.n        = 2'd0;
    res_o.wr_en    = 1'b0;
    res_o.wr_entry = repl;
    res_o.r0 = rbt_pkg::make_result(item_i.resource_index, rbt_pkg::BK_HAZARD,
                                    prev, req, asp, 1'b1);
    res_o.r1 = rbt_pkg::make_result(item_i.resource_index, rbt_pkg::BK_ACQUIRE,
                                    zs, req, asp, 1'b1);

    if (!in_range) begin
      res_o.n = 2'd0;
    end else if (item_i.operation == rbt_pkg::OP_DECLARE) begin
      res_o.wr_en    = 1'b1;
      res_o.wr_entry = decl;
    end else if (tex && (prev.lay == rbt_pkg::LAY_UNDEF || prev.lay != req.lay)) begin
      res_o.n     = 2'd1;
      res_o.wr_en = 1'b1;
    end else if (prev.fam != req.fam) begin
      res_o.wr_en = 1'b1;
      if (!item_i.first_pass) begin
        res_o.n  = 2'd2;
        res_o.r0 = rbt_pkg::make_result(item_i.resource_index, rbt_pkg::BK_RELEASE,
                                        prev, zd, asp, 1'b0);
      end else begin
        res_o.n  = 2'd1;
        res_o.r0 = rbt_pkg::make_result(item_i.resource_index, rbt_pkg::BK_ACQUIRE,
                                        zs, req, asp, 1'b1);
      end
    end else if (((prev.acc | req.acc) & rbt_pkg::WRITE_BITS) != '0) begin
      res_o.n     = 2'd1;
      res_o.wr_en = 1'b1;
    end else begin
      res_o.wr_en    = 1'b1;
      res_o.wr_entry = merged;
    end
  end

endmodule

`default_nettype wire

// ===== design/rbt_checker.sv =====
// Port-level checks of the resource barrier tracker, bound to the top level.
`default_nettype none

module rbt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic        out_last_i,
  input logic [16:0] out_src_access_i,
  input logic [34:0] out_src_stages_i
);

  // a waiting beat is not withdrawn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // one item at a time: no accept on the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while previous item still resolving");

  // a release is never the final beat and is followed at once by its acquisition
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == rbt_pkg::BK_RELEASE |-> !out_last_i)
    else $error("release beat marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_kind_i == rbt_pkg::BK_RELEASE
    |=> out_valid_i && out_kind_i == rbt_pkg::BK_ACQUIRE)
    else $error("release not followed by acquisition");

  // acquisition side of an ownership transfer carries no source scope
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == rbt_pkg::BK_ACQUIRE
    |-> out_src_access_i == '0 && out_src_stages_i == '0 && out_last_i)
    else $error("acquisition with source access or stages");

endmodule

bind resource_barrier_tracker_core rbt_checker u_rbt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (item_i.valid),
  .in_ready_i      (item_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .out_kind_i      (result_o.barrier_kind),
  .out_last_i      (result_o.last),
  .out_src_access_i(result_o.src_access),
  .out_src_stages_i(result_o.src_stages)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for resource_barrier_tracker_core: predicts barrier beats per item.
`timescale 1ns / 100ps

module testbench;
  import rbt_pkg::*;

  localparam logic [2:0] USE_UNDEF = 3'd6;
  localparam logic [2:0] USE_TOP   = 3'd7;

  typedef struct packed {
    logic [3:0]       fam;
    logic [ACC_W-1:0] acc;
    logic [STG_W-1:0] stg;
    logic [2:0]       lay;
  } track_state_t;

  // Tracks the resource table and family registers, holds the barrier beats still due.
  class barrier_ledger;
    localparam logic [63:0] STG_CLEAR    = 64'h08_0000_0000;
    localparam logic [63:0] STG_INDEX_IN = 64'h10_0000_0000;
    localparam logic [63:0] STG_VATTR_IN = 64'h20_0000_0000;
    localparam logic [2:0]  ASP_COLOR    = 3'b001;
    localparam logic [2:0]  ASP_DEPTH    = 3'b010;
    localparam logic [2:0]  ASP_STENCIL  = 3'b100;

    logic [3:0]       fam_gfx, fam_xfer, fam_comp;
    logic             kind_tab   [MAX_RESOURCES];
    logic [2:0]       aspect_tab [MAX_RESOURCES];
    logic [3:0]       owner_tab  [MAX_RESOURCES];
    logic [3:0]       family_tab [MAX_RESOURCES];
    logic [ACC_W-1:0] access_tab [MAX_RESOURCES];
    logic [STG_W-1:0] stage_tab  [MAX_RESOURCES];
    logic [2:0]       layout_tab [MAX_RESOURCES];
    result_t          pending [$];
    int               errors;
    int               beats;

    function new();
      fam_gfx  = '0;
      fam_xfer = '0;
      fam_comp = '0;
      errors   = 0;
      beats    = 0;
    endfunction

    function void note_write(logic [1:0] idx, logic [3:0] val);
      case (idx)
        CFG_GRAPHICS: fam_gfx  = val;
        CFG_TRANSFER: fam_xfer = val;
        CFG_COMPUTE:  fam_comp = val;
        default: ;
      endcase
    endfunction

    function void push_barrier(logic [7:0] idx, logic [1:0] bk, track_state_t s,
                               track_state_t d, logic [2:0] asp, logic fin);
      result_t r;
      r.barrier_resource = idx;
      r.barrier_kind     = bk;
      r.src_access       = s.acc;
      r.src_stages       = s.stg;
      r.src_layout       = s.lay;
      r.src_family       = s.fam;
      r.dst_access       = d.acc;
      r.dst_stages       = d.stg;
      r.dst_layout       = d.lay;
      r.dst_family       = d.fam;
      r.aspect_mask      = asp;
      r.last             = fin;
      pending = {pending, r};
    endfunction

    function void take_item(item_t it);
      logic [7:0]   idx;
      logic         tex;
      logic         wr;
      logic [2:0]   asp;
      logic [63:0]  stg_full;
      track_state_t was, want, zs, zd;
      idx = it.resource_index;
      wr  = it.is_write;
      if (it.operation == OP_DECLARE) begin
        kind_tab[idx]   = it.is_texture;
        owner_tab[idx]  = it.owner_family;
        aspect_tab[idx] = it.image_aspects;
        family_tab[idx] = it.owner_family;
        access_tab[idx] = '0;
        stage_tab[idx]  = S_ALL_CMDS;
        layout_tab[idx] = LAY_UNDEF;
        return;
      end
      tex     = kind_tab[idx];
      was.fam = family_tab[idx];
      was.acc = access_tab[idx];
      was.stg = stage_tab[idx];
      was.lay = tex ? layout_tab[idx] : LAY_UNDEF;

      // required state of this binding
      want     = '0;
      stg_full = '0;
      if (it.queue_kind == Q_NONE) begin
        want.fam = owner_tab[idx];
        stg_full = S_ALL_CMDS;
      end else begin
        case (it.queue_kind)
          Q_GRAPHICS: want.fam = fam_gfx;
          Q_TRANSFER: want.fam = fam_xfer;
          default:    want.fam = fam_comp;
        endcase
        if (tex) begin
          case (it.usage)
            UI_COLOR: begin
              want.acc = wr ? A_COLOR_WR : A_COLOR_RD;
              stg_full = S_COLOR_OUT;
              want.lay = LAY_COLOR;
            end
            UI_DEPTH: begin
              want.acc = wr ? A_DS_WR : A_DS_RD;
              stg_full = S_EARLY_FT | S_LATE_FT;
              want.lay = wr ? LAY_DS_ATT : LAY_DS_RD;
            end
            UI_SHADER: begin
              want.acc = wr ? A_SHADER_WR : A_SHADER_RD;
              stg_full = S_FRAG | S_COMPUTE;
              want.lay = wr ? LAY_DS_RD : LAY_SHADER_RD;
            end
            UI_TRANSFER: begin
              want.acc = wr ? A_XFER_WR : A_XFER_RD;
              stg_full = S_COPY | STG_CLEAR;
              want.lay = wr ? LAY_XFER_DST : LAY_XFER_SRC;
            end
            UI_PRESENT: want.lay = LAY_PRESENT;
            default: ;
          endcase
        end else begin
          case (it.usage)
            UB_STORAGE: begin
              want.acc = wr ? A_SHADER_WR : A_SHADER_RD;
              stg_full = S_FRAG | S_COMPUTE;
            end
            UB_UNIFORM: begin
              want.acc = A_UNIFORM_RD;
              stg_full = S_FRAG | S_COMPUTE;
            end
            UB_VERTEX: begin
              want.acc = A_VERTEX_RD;
              stg_full = STG_VATTR_IN;
            end
            UB_INDEX: begin
              want.acc = A_INDEX_RD;
              stg_full = STG_INDEX_IN;
            end
            UB_TRANSFER: begin
              want.acc = wr ? A_XFER_WR : A_XFER_RD;
              stg_full = S_COPY | STG_CLEAR;
            end
            UB_HOST: begin
              want.acc = wr ? A_HOST_WR : A_HOST_RD;
              stg_full = S_HOST;
            end
            default: ;
          endcase
        end
      end
      // stage bits above the field width are lost
      want.stg = stg_full[STG_W-1:0];

      case (it.usage)
        UI_COLOR, UI_TRANSFER, UI_PRESENT: asp = ASP_COLOR;
        UI_DEPTH:                          asp = ASP_DEPTH | ASP_STENCIL;
        UI_SHADER:                         asp = ASP_COLOR | ASP_DEPTH;
        default:                           asp = 3'b000;
      endcase
      asp = tex ? (asp & aspect_tab[idx]) : 3'b000;

      if (tex && (was.lay == LAY_UNDEF || was.lay != want.lay)) begin
        push_barrier(idx, BK_HAZARD, was, want, asp, 1'b1);
      end else if (was.fam != want.fam) begin
        zs     = was;
        zs.acc = '0;
        zs.stg = '0;
        zd     = want;
        zd.acc = '0;
        zd.stg = '0;
        if (!it.first_pass) begin
          push_barrier(idx, BK_RELEASE, was, zd, asp, 1'b0);
        end
        push_barrier(idx, BK_ACQUIRE, zs, want, asp, 1'b1);
      end else if (((was.acc | want.acc) & WRITE_BITS) != '0) begin
        push_barrier(idx, BK_HAZARD, was, want, asp, 1'b1);
      end else begin
        access_tab[idx] = was.acc | want.acc;
        stage_tab[idx]  = was.stg | want.stg;
        return;
      end
      family_tab[idx] = want.fam;
      access_tab[idx] = want.acc;
      stage_tab[idx]  = want.stg;
      layout_tab[idx] = want.lay;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) begin
        $display("[%0t] beat %0d: %s", $time, beats, msg);
      end
    endtask

    task cmp(string name, logic [34:0] got, logic [34:0] want);
      if (got !== want) begin
        report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
      end
    endtask

    task match_barrier(result_t got);
      result_t want;
      beats++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat for resource %0d", got.barrier_resource));
        return;
      end
      want = pending.pop_front();
      cmp("barrier_resource", got.barrier_resource, want.barrier_resource);
      cmp("barrier_kind", got.barrier_kind, want.barrier_kind);
      cmp("src_access", got.src_access, want.src_access);
      cmp("src_stages", got.src_stages, want.src_stages);
      cmp("src_layout", got.src_layout, want.src_layout);
      cmp("src_family", got.src_family, want.src_family);
      cmp("dst_access", got.dst_access, want.dst_access);
      cmp("dst_stages", got.dst_stages, want.dst_stages);
      cmp("dst_layout", got.dst_layout, want.dst_layout);
      cmp("dst_family", got.dst_family, want.dst_family);
      cmp("aspect_mask", got.aspect_mask, want.aspect_mask);
      cmp("last", got.last, want.last);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  rbt_item_if   item ();
  rbt_result_if res ();
  rbt_cfg_if    cfg ();

  resource_barrier_tracker_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item),
    .result_o (res),
    .cfg_i    (cfg)
  );

  barrier_ledger sb = new();
  logic          declared [MAX_RESOURCES];
  bit            calm_in;
  bit            calm_out;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic int pick_gap(bit calm);
    int roll;
    if (calm) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t mk(logic op, logic [7:0] idx, logic tex, logic [3:0] own,
                               logic [2:0] asp, logic [1:0] q, logic [2:0] usg,
                               logic wr, logic fst);
    item_t it;
    it.operation      = op;
    it.resource_index = idx;
    it.is_texture     = tex;
    it.owner_family   = own;
    it.image_aspects  = asp;
    it.queue_kind     = q;
    it.usage          = usg;
    it.is_write       = wr;
    it.first_pass     = fst;
    return it;
  endfunction

  task automatic put_item(input item_t it);
    int gap;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.valid          <= 1'b1;
    item.operation      <= it.operation;
    item.resource_index <= it.resource_index;
    item.is_texture     <= it.is_texture;
    item.owner_family   <= it.owner_family;
    item.image_aspects  <= it.image_aspects;
    item.queue_kind     <= it.queue_kind;
    item.usage          <= it.usage;
    item.is_write       <= it.is_write;
    item.first_pass     <= it.first_pass;
    do @(posedge clk_i); while (item.ready !== 1'b1);
    if (it.operation == OP_DECLARE) begin
      declared[it.resource_index] = 1'b1;
    end
    sb.take_item(it);
  endtask

  task automatic set_families(input fam_cfg_t f);
    logic [1:0] regs [3];
    logic [3:0] vals [3];
    regs = '{CFG_GRAPHICS, CFG_TRANSFER, CFG_COMPUTE};
    vals = '{f.graphics, f.transfer, f.compute};
    for (int k = 0; k < 3; k++) begin
      cfg.valid <= 1'b1;
      cfg.index <= regs[k];
      cfg.data  <= vals[k];
      do @(posedge clk_i); while (cfg.ready !== 1'b1);
      sb.note_write(regs[k], vals[k]);
    end
    cfg.valid <= 1'b0;
  endtask

  // Let all due beats arrive, then give silent items time to finish their write-back.
  task automatic drain();
    item.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
      sb.match_barrier(result_t'{res.barrier_resource, res.barrier_kind, res.src_access,
                                 res.src_stages, res.src_layout, res.src_family,
                                 res.dst_access, res.dst_stages, res.dst_layout,
                                 res.dst_family, res.aspect_mask, res.last});
    end
  end

  initial begin : sink_side
    int hold;
    int cyc;
    hold      = 0;
    cyc       = 0;
    calm_out  = 1'b0;
    res.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 64 == 0) begin
        calm_out = ($urandom_range(0, 3) == 0);
      end
      if (hold > 0) begin
        hold--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        hold = pick_gap(calm_out);
      end
    end
  end

  initial begin : stimulus
    fam_cfg_t   plan [6];
    logic [7:0] hot [8];
    item_t      it;
    rst_ni              <= 1'b0;
    item.valid          <= 1'b0;
    item.operation      <= OP_DECLARE;
    item.resource_index <= '0;
    item.is_texture     <= 1'b0;
    item.owner_family   <= '0;
    item.image_aspects  <= '0;
    item.queue_kind     <= Q_NONE;
    item.usage          <= UI_COLOR;
    item.is_write       <= 1'b0;
    item.first_pass     <= 1'b0;
    cfg.valid           <= 1'b0;
    cfg.index           <= CFG_GRAPHICS;
    cfg.data            <= '0;
    calm_in = 1'b0;
    foreach (declared[k]) declared[k] = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: graphics 1, transfer 2, compute 15
    set_families(fam_cfg_t'{4'd1, 4'd2, 4'd15});
    put_item(mk(OP_DECLARE, 8'd0, 1'b1, 4'd1, 3'd7, Q_NONE, UI_COLOR, 1'b0, 1'b0));
    put_item(mk(OP_DECLARE, 8'd255, 1'b0, 4'd15, 3'd0, Q_NONE, UI_COLOR, 1'b0, 1'b0));
    put_item(mk(OP_DECLARE, 8'd85, 1'b1, 4'd0, 3'd1, Q_NONE, UI_COLOR, 1'b0, 1'b0));
    // image: layout from undefined, write hazard, then a silent read merge
    put_item(mk(OP_BIND, 8'd0, 1'b0, 4'd0, 3'd0, Q_GRAPHICS, UI_COLOR, 1'b1, 1'b1));
    put_item(mk(OP_BIND, 8'd0, 1'b0, 4'd0, 3'd0, Q_GRAPHICS, UI_COLOR, 1'b0, 1'b0));
    put_item(mk(OP_BIND, 8'd0, 1'b0, 4'd0, 3'd0, Q_GRAPHICS, UI_COLOR, 1'b0, 1'b0));
    // layout change wins over family change; then ownership with and without release
    put_item(mk(OP_BIND, 8'd0, 1'b0, 4'd0, 3'd0, Q_COMPUTE, UI_DEPTH, 1'b1, 1'b0));
    put_item(mk(OP_BIND, 8'd0, 1'b0, 4'd0, 3'd0, Q_TRANSFER, UI_DEPTH, 1'b1, 1'b0));
    put_item(mk(OP_BIND, 8'd0, 1'b0, 4'd0, 3'd0, Q_GRAPHICS, UI_DEPTH, 1'b1, 1'b1));
    // shader write lands in the ds read layout
    put_item(mk(OP_BIND, 8'd0, 1'b0, 4'd0, 3'd0, Q_GRAPHICS, UI_SHADER, 1'b1, 1'b0));
    put_item(mk(OP_BIND, 8'd0, 1'b0, 4'd0, 3'd0, Q_GRAPHICS, UI_DEPTH, 1'b0, 1'b0));
    put_item(mk(OP_BIND, 8'd0, 1'b0, 4'd0, 3'd0, Q_TRANSFER, UI_TRANSFER, 1'b0, 1'b0));
    put_item(mk(OP_BIND, 8'd0, 1'b0, 4'd0, 3'd0, Q_TRANSFER, UI_TRANSFER, 1'b1, 1'b0));
    put_item(mk(OP_BIND, 8'd0, 1'b0, 4'd0, 3'd0, Q_GRAPHICS, UI_PRESENT, 1'b0, 1'b0));
    put_item(mk(OP_BIND, 8'd0, 1'b0, 4'd0, 3'd0, Q_GRAPHICS, USE_UNDEF, 1'b0, 1'b0));
    put_item(mk(OP_BIND, 8'd0, 1'b0, 4'd0, 3'd0, Q_NONE, UI_COLOR, 1'b0, 1'b0));
    put_item(mk(OP_BIND, 8'd85, 1'b1, 4'd15, 3'd7, Q_COMPUTE, UI_SHADER, 1'b0, 1'b0));
    // buffer: reads and host write merge silently on the owning family
    put_item(mk(OP_BIND, 8'd255, 1'b1, 4'd0, 3'd0, Q_COMPUTE, UB_STORAGE, 1'b0, 1'b0));
    put_item(mk(OP_BIND, 8'd255, 1'b0, 4'd0, 3'd0, Q_COMPUTE, UB_UNIFORM, 1'b0, 1'b0));
    put_item(mk(OP_BIND, 8'd255, 1'b0, 4'd0, 3'd0, Q_COMPUTE, UB_VERTEX, 1'b0, 1'b0));
    put_item(mk(OP_BIND, 8'd255, 1'b0, 4'd0, 3'd0, Q_COMPUTE, UB_INDEX, 1'b0, 1'b0));
    put_item(mk(OP_BIND, 8'd255, 1'b0, 4'd0, 3'd0, Q_COMPUTE, UB_HOST, 1'b1, 1'b0));
    put_item(mk(OP_BIND, 8'd255, 1'b0, 4'd0, 3'd0, Q_GRAPHICS, UB_TRANSFER, 1'b1, 1'b0));
    put_item(mk(OP_BIND, 8'd255, 1'b0, 4'd0, 3'd0, Q_GRAPHICS, USE_TOP, 1'b0, 1'b0));
    put_item(mk(OP_BIND, 8'd255, 1'b0, 4'd0, 3'd0, Q_NONE, UB_STORAGE, 1'b0, 1'b1));
    drain();

    plan[0] = fam_cfg_t'{4'd0, 4'd0, 4'd0};
    plan[1] = fam_cfg_t'{4'd15, 4'd15, 4'd15};
    plan[2] = fam_cfg_t'{4'd3, 4'd9, 4'd3};
    plan[3] = fam_cfg_t'{4'd15, 4'd0, 4'd7};
    plan[4] = fam_cfg_t'{4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15))};
    plan[5] = fam_cfg_t'{4'd0, 4'd15, 4'd0};

    for (int p = 0; p < 6; p++) begin
      set_families(plan[p]);
      foreach (hot[k]) hot[k] = 8'($urandom_range(0, 255));
      for (int n = 0; n < 230; n++) begin
        if (n % 48 == 0) begin
          calm_in = ($urandom_range(0, 3) == 0);
        end
        it.operation      = ($urandom_range(0, 99) < 12) ? OP_DECLARE : OP_BIND;
        it.resource_index = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 7)]
                                                        : 8'($urandom_range(0, 255));
        // never bind an entry that holds no declared state
        if (!declared[it.resource_index]) begin
          it.operation = OP_DECLARE;
        end
        it.is_texture    = 1'($urandom_range(0, 1));
        it.owner_family  = $urandom_range(0, 1) ? plan[p].compute
                                                : 4'($urandom_range(0, 15));
        it.image_aspects = 3'($urandom_range(0, 7));
        it.queue_kind    = ($urandom_range(0, 9) == 0) ? Q_NONE : 2'($urandom_range(1, 3));
        it.usage         = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(USE_UNDEF, USE_TOP))
                                                       : 3'($urandom_range(0, 5));
        it.is_write      = 1'($urandom_range(0, 1));
        it.first_pass    = ($urandom_range(0, 3) == 0);
        put_item(it);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/rbt_pkg.sv
design/rbt_if.sv
design/rbt_resolve.sv
design/resource_barrier_tracker_core.sv
design/rbt_checker.sv
sim/testbench.sv
